// ===== hdl/tpse_pkg.sv =====
// shared types and constants of the tape pulse stream encoder
package tpse_pkg;

  localparam int TPSE_QUEUE_DEPTH = 4;

  localparam logic [30:0] PULSE_LIMIT = 31'h7FFF_FFFF;
  localparam logic [14:0] RUN_MAX     = 15'h7FFF;
  localparam logic [15:0] WORD_FLAG   = 16'h8000;

  typedef enum logic [1:0] {
    OP_PULSE,
    OP_END,
    OP_FLUSH
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [30:0] len;
  } op_t;

  typedef struct packed {
    logic        word_vld;
    logic        end_vld;
    logic [15:0] word;
  } gen_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PIECE,
    F_JOIN,
    F_END,
    F_FLUSH
  } front_state_t;

endpackage

// ===== hdl/tpse_front.sv =====
// front end: takes segments and flushes, builds pulses and queues pulse operations
module tpse_front import tpse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_func,
  input  logic [31:0] in_dur,
  input  logic        in_level,
  output op_t         op,
  output logic        op_vld,
  input  logic        op_rdy
);

  front_state_t st_r, st_nxt;
  logic [31:0]  rem_r, rem_nxt;
  logic         lvl_r, lvl_nxt;
  logic         cur_level_r, cur_level_nxt;
  logic [30:0]  cur_length_r, cur_length_nxt;

  logic         last_piece;
  logic [30:0]  piece;
  logic [31:0]  sum;
  logic         done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= F_IDLE;
      cur_level_r  <= 1'b0;
      cur_length_r <= '0;
    end else begin
      st_r         <= st_nxt;
      cur_level_r  <= cur_level_nxt;
      cur_length_r <= cur_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lvl_r <= lvl_nxt;
  end

  always_comb begin
    st_nxt         = st_r;
    rem_nxt        = rem_r;
    lvl_nxt        = lvl_r;
    cur_level_nxt  = cur_level_r;
    cur_length_nxt = cur_length_r;
    op_vld         = 1'b0;
    op.kind        = OP_END;
    op.len         = '0;
    done           = 1'b0;
    last_piece     = !rem_r[31];
    piece          = last_piece ? rem_r[30:0] : PULSE_LIMIT;
    sum            = {1'b0, cur_length_r} + {1'b0, piece};

    unique case (st_r)
      F_IDLE: begin
      end
      F_PIECE: begin
        if (piece == '0) begin
          op_vld  = 1'b1;
          op.kind = OP_END;
          done    = op_rdy;
        end else if (lvl_r != cur_level_r) begin
          // level change closes the pulse in progress
          op_vld  = 1'b1;
          op.kind = OP_PULSE;
          op.len  = cur_length_r;
          if (op_rdy) begin
            cur_length_nxt = '0;
            cur_level_nxt  = lvl_r;
          end
        end else if (sum[31]) begin
          // too long: cut at the limit, zero joiner follows
          op_vld  = 1'b1;
          op.kind = OP_PULSE;
          op.len  = PULSE_LIMIT;
          if (op_rdy) begin
            cur_length_nxt = sum[30:0] + 31'd1;
            st_nxt         = F_JOIN;
          end
        end else if (last_piece) begin
          op_vld  = 1'b1;
          op.kind = OP_END;
          done    = op_rdy;
          if (op_rdy) begin
            cur_length_nxt = sum[30:0];
          end
        end else begin
          cur_length_nxt = sum[30:0];
          rem_nxt        = rem_r - {1'b0, PULSE_LIMIT};
        end
      end
      F_JOIN: begin
        op_vld  = 1'b1;
        op.kind = OP_PULSE;
        op.len  = '0;
        if (op_rdy) begin
          if (last_piece) begin
            st_nxt = F_END;
          end else begin
            rem_nxt = rem_r - {1'b0, PULSE_LIMIT};
            st_nxt  = F_PIECE;
          end
        end
      end
      F_END: begin
        op_vld  = 1'b1;
        op.kind = OP_END;
        done    = op_rdy;
      end
      F_FLUSH: begin
        op_vld = 1'b1;
        if (cur_length_r != '0) begin
          op.kind = OP_PULSE;
          op.len  = cur_length_r;
          if (op_rdy) begin
            cur_length_nxt = '0;
          end
        end else begin
          op.kind = OP_FLUSH;
          done    = op_rdy;
          if (op_rdy) begin
            cur_level_nxt = 1'b0;
          end
        end
      end
      default: begin
        st_nxt = F_IDLE;
      end
    endcase

    if (done) begin
      st_nxt = F_IDLE;
    end
    in_tready = (st_r == F_IDLE) | done;
    if (in_tvalid && in_tready) begin
      rem_nxt = in_dur;
      lvl_nxt = in_level;
      st_nxt  = in_func ? F_FLUSH : F_PIECE;
    end
  end

endmodule

// ===== hdl/tpse_queue.sv =====
// short queue of pulse operations between front and back end
module tpse_queue import tpse_pkg::*; #(
  parameter int DEPTH = TPSE_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  op_t  push_op,
  input  logic push_vld,
  output logic push_rdy,
  output op_t  pop_op,
  output logic pop_vld,
  input  logic pop
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  op_t             mem_r [DEPTH];
  logic [IdxW-1:0] wr_r, wr_nxt;
  logic [IdxW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_rdy = (cnt_r != FullCnt);
  assign pop_vld  = (cnt_r != '0);
  assign pop_op   = mem_r[rd_r];
  assign do_push  = push_vld & push_rdy;
  assign do_pop   = pop & pop_vld;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LastIdx) ? '0 : wr_r + IdxW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LastIdx) ? '0 : rd_r + IdxW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_op;
    end
  end

endmodule

// ===== hdl/tpse_back.sv =====
// back end: run counting of pulses and code word generation
module tpse_back import tpse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  op_t  op,
  input  logic op_vld,
  output logic op_pop,
  output gen_t gen,
  input  logic gen_rdy
);

  logic [14:0] run_count_r, run_count_nxt;
  logic [30:0] run_length_r, run_length_nxt;
  logic [1:0]  ph_r, ph_nxt;

  logic        has_cnt;
  logic        long_len;
  logic [15:0] w1;
  logic [15:0] list0, list1, list2;
  logic [1:0]  last_ph;
  logic        at_last;
  logic        store;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r  <= '0;
      run_length_r <= '0;
      ph_r         <= '0;
    end else begin
      run_count_r  <= run_count_nxt;
      run_length_r <= run_length_nxt;
      ph_r         <= ph_nxt;
    end
  end

  always_comb begin
    has_cnt  = (run_count_r > 15'd1) | (|run_length_r[30:16]);
    long_len = |run_length_r[30:15];
    w1       = long_len ? (WORD_FLAG | {1'b0, run_length_r[30:16]})
                        : {1'b0, run_length_r[14:0]};
    list0    = has_cnt ? (WORD_FLAG | {1'b0, run_count_r}) : w1;
    list1    = has_cnt ? w1 : run_length_r[15:0];
    list2    = run_length_r[15:0];
    last_ph  = {1'b0, has_cnt} + {1'b0, long_len};
    at_last  = (ph_r == last_ph);
    store    = (run_count_r != '0) &&
               !((op.len == run_length_r) && (run_count_r != RUN_MAX));

    run_count_nxt  = run_count_r;
    run_length_nxt = run_length_r;
    ph_nxt         = ph_r;
    op_pop         = 1'b0;
    gen.word_vld   = 1'b0;
    gen.end_vld    = 1'b0;
    case (ph_r)
      2'd0:    gen.word = list0;
      2'd1:    gen.word = list1;
      default: gen.word = list2;
    endcase

    if (op_vld) begin
      unique case (op.kind)
        OP_PULSE: begin
          if (!store) begin
            op_pop = 1'b1;
            if (run_count_r == '0) begin
              run_length_nxt = op.len;
              run_count_nxt  = 15'd1;
            end else begin
              run_count_nxt = run_count_r + 15'd1;
            end
          end else begin
            gen.word_vld = 1'b1;
            if (gen_rdy) begin
              if (at_last) begin
                op_pop         = 1'b1;
                ph_nxt         = '0;
                run_length_nxt = op.len;
                run_count_nxt  = 15'd1;
              end else begin
                ph_nxt = ph_r + 2'd1;
              end
            end
          end
        end
        OP_FLUSH: begin
          if (run_count_r == '0) begin
            gen.end_vld = 1'b1;
            op_pop      = 1'b1;
          end else begin
            gen.word_vld = 1'b1;
            gen.end_vld  = at_last;
            if (gen_rdy) begin
              if (at_last) begin
                op_pop        = 1'b1;
                ph_nxt        = '0;
                run_count_nxt = '0;
              end else begin
                ph_nxt = ph_r + 2'd1;
              end
            end
          end
        end
        OP_END: begin
          gen.end_vld = 1'b1;
          op_pop      = 1'b1;
        end
        default: begin
          op_pop = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hdl/tpse_out.sv =====
// output side: holds one word back until its end flag is known, then output register
module tpse_out import tpse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gen_t        gen,
  output logic        gen_rdy,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  logic        h_vld_r, h_vld_nxt;
  logic        h_last_r, h_last_nxt;
  logic [15:0] h_word_r, h_word_nxt;
  logic        o_vld_r, o_vld_nxt;
  logic        o_last_r, o_last_nxt;
  logic [15:0] o_word_r, o_word_nxt;
  logic        o_free;
  logic        move;

  always_comb begin
    o_free  = !o_vld_r | out_tready;
    gen_rdy = !h_vld_r | o_free;
    move    = h_vld_r & o_free & (gen.word_vld | h_last_r);

    o_vld_nxt  = o_vld_r;
    o_last_nxt = o_last_r;
    o_word_nxt = o_word_r;
    h_vld_nxt  = h_vld_r;
    h_last_nxt = h_last_r;
    h_word_nxt = h_word_r;

    if (move) begin
      o_vld_nxt  = 1'b1;
      o_word_nxt = h_word_r;
      o_last_nxt = h_last_r;
    end else if (out_tready) begin
      o_vld_nxt = 1'b0;
    end

    if (gen.word_vld && gen_rdy) begin
      h_vld_nxt  = 1'b1;
      h_word_nxt = gen.word;
      h_last_nxt = gen.end_vld;
    end else if (move) begin
      h_vld_nxt = 1'b0;
    end else if (gen.end_vld && !gen.word_vld && h_vld_r) begin
      h_last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      h_vld_r <= h_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_last_r <= h_last_nxt;
    h_word_r <= h_word_nxt;
    o_last_r <= o_last_nxt;
    o_word_r <= o_word_nxt;
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_word_r;
  assign out_tlast  = o_last_r;

endmodule

// ===== hdl/tape_pulse_stream_encoder.sv =====
// top level of the tape pulse stream encoder
//
//  channel | direction | tdata                                   | tuser | tlast
//  in_     | slave     | [31:0] seg_duration, [32] seg_level     | func  | -
//  out_    | master    | [15:0] code_word                        | -     | word_last
//
//  front end: queues pulses and end markers, and adds up a long segment piece by piece
//  a level change closes the pulse, a cut adds a zero joiner, a flush queues any open pulse first
//  the back end emits one code word per cycle while output is ready, and merges equal pulses
//  the front end takes a new item once it has queued the last; up to 18 words per item
//  synchronous active-low reset clears pulse and run state and empties the queue
//  the front end stalls on a full queue only; output stalls back up through the queue
module tape_pulse_stream_encoder import tpse_pkg::*; #(
  parameter int QUEUE_DEPTH = TPSE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] seg_duration, [32] seg_level, [39:33] zero
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_word
  output logic        out_tlast
);

  op_t  f_op;
  logic f_op_vld;
  logic f_op_rdy;
  op_t  q_op;
  logic q_op_vld;
  logic q_pop;
  gen_t gen;
  logic gen_rdy;

  tpse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .in_dur    (in_tdata[31:0]),
    .in_level  (in_tdata[32]),
    .op        (f_op),
    .op_vld    (f_op_vld),
    .op_rdy    (f_op_rdy)
  );

  tpse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_op  (f_op),
    .push_vld (f_op_vld),
    .push_rdy (f_op_rdy),
    .pop_op   (q_op),
    .pop_vld  (q_op_vld),
    .pop      (q_pop)
  );

  tpse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (q_op),
    .op_vld  (q_op_vld),
    .op_pop  (q_pop),
    .gen     (gen),
    .gen_rdy (gen_rdy)
  );

  tpse_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .gen        (gen),
    .gen_rdy    (gen_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hdl/tpse_checker.sv =====
// port-level checks of the tape pulse stream encoder and their binding
module tpse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // reset leaves no word on the output
  a_rst_out_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // reset leaves the front end ready for a new item
  a_rst_in_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // a stalled transfer keeps its word and end flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind tape_pulse_stream_encoder tpse_checker u_chk (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the tape pulse stream encoder with a code word predictor
module testbench;
  import tpse_pkg::*;

  localparam bit FUNC_SEGMENT = 1'b0;
  localparam bit FUNC_FLUSH   = 1'b1;
  localparam int MAX_WORDS    = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } code_word_t;

  class code_word_tracker;
    bit         cur_lvl;
    bit [31:0]  cur_len;
    bit [14:0]  run_cnt;
    bit [30:0]  run_len;
    bit [15:0]  step_words[$];
    code_word_t expected_words[$];
    int         errors;

    function void put_word(bit [15:0] w);
      if (step_words.size() < MAX_WORDS) step_words.push_back(w);
    endfunction

    function void store_run(bit [14:0] cnt, bit [30:0] len);
      if (cnt > 1 || len > 31'hFFFF) put_word(WORD_FLAG | {1'b0, cnt});
      if (len < 31'h8000) begin
        put_word(len[15:0]);
      end else begin
        put_word(WORD_FLAG | {1'b0, len[30:16]});
        put_word(len[15:0]);
      end
    endfunction

    function void add_pulse(bit [30:0] len);
      if (run_cnt > 0) begin
        if (run_len == len && run_cnt < RUN_MAX) begin
          run_cnt++;
          return;
        end
        store_run(run_cnt, run_len);
      end
      run_len = len;
      run_cnt = 1;
    endfunction

    function void add_segment(bit [31:0] dur, bit lvl);
      bit [32:0] sum;
      if (dur == 0) return;
      if (lvl != cur_lvl) begin
        add_pulse(cur_len[30:0]);
        cur_len = 0;
        cur_lvl = lvl;
      end
      sum = {1'b0, cur_len} + {1'b0, dur};
      // pulse above the limit: cut it and add a zero-length joiner
      if (sum > {2'b0, PULSE_LIMIT}) begin
        add_pulse(PULSE_LIMIT);
        add_pulse('0);
        sum -= {2'b0, PULSE_LIMIT};
      end
      cur_len = sum[31:0];
    endfunction

    function void note_input(bit func, bit [31:0] dur, bit lvl);
      code_word_t e;
      step_words.delete();
      if (func == FUNC_SEGMENT) begin
        while (dur > {1'b0, PULSE_LIMIT}) begin
          add_segment({1'b0, PULSE_LIMIT}, lvl);
          dur -= {1'b0, PULSE_LIMIT};
        end
        add_segment(dur, lvl);
      end else begin
        if (cur_len > 0) begin
          add_pulse(cur_len[30:0]);
          cur_len = 0;
        end
        cur_lvl = 1'b0;
        if (run_cnt > 0) begin
          store_run(run_cnt, run_len);
          run_cnt = 0;
        end
      end
      foreach (step_words[i]) begin
        e.word = step_words[i];
        e.last = (i == step_words.size() - 1);
        expected_words.push_back(e);
      end
    endfunction

    function void check_word(logic [15:0] word, logic last);
      code_word_t e;
      if (expected_words.size() == 0) begin
        $error("code_word: expected none, actual %h", word);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (word !== e.word) begin
        $error("code_word: expected %h, actual %h", e.word, word);
        errors++;
      end
      if (last !== e.last) begin
        $error("word_last: expected %b, actual %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [31:0] seg_duration, [32] seg_level, [39:33] zero
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] code_word
  logic        out_tlast;

  code_word_tracker sb;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int cycle_count;
  int hold_left;
  bit hold_req;
  bit hold_done;
  bit lvl_now;

  tape_pulse_stream_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check the transfer, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(bit func, bit [31:0] dur, bit lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, lvl, dur};
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    sb.note_input(func, dur, lvl);
    if (func == FUNC_FLUSH || dur != 0) items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic random_block();
    int        mode;
    int        k;
    bit [31:0] len;
    bit [31:0] part;
    bit [31:0] dur;
    mode = $urandom_range(99);
    if (mode < 60) begin
      // train of alternating pulses of one length
      case ($urandom_range(4))
        0: len = $urandom_range(1, 12);
        1: len = 32'h7FFE + $urandom_range(0, 3);
        2: len = 32'hFFFE + $urandom_range(0, 3);
        3: len = 32'h7FFF_FFFE + $urandom_range(0, 3);
        default: len = $urandom >> $urandom_range(31);
      endcase
      k = $urandom_range(1, 6);
      repeat (k) begin
        lvl_now = ~lvl_now;
        if (len > 1 && $urandom_range(3) == 0) begin
          part = $urandom_range(1, len - 1);
          send_item(FUNC_SEGMENT, part, lvl_now);
          send_item(FUNC_SEGMENT, len - part, lvl_now);
        end else begin
          send_item(FUNC_SEGMENT, len, lvl_now);
        end
      end
    end else if (mode < 92) begin
      dur = $urandom;
      if ($urandom_range(1)) dur = dur >> $urandom_range(31);
      if ($urandom_range(9) == 0) dur = 0;
      lvl_now = 1'($urandom_range(1));
      send_item($urandom_range(9) == 0 ? FUNC_FLUSH : FUNC_SEGMENT, dur, lvl_now);
    end else begin
      send_item(FUNC_FLUSH, $urandom, 1'($urandom_range(1)));
      lvl_now = 1'b0;
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 36;
    recv_idle_pct = 88;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // leading high, ignored zero, run of equal pulses
    send_item(FUNC_SEGMENT, 32'd5, 1'b1);
    send_item(FUNC_SEGMENT, 32'd0, 1'b0);
    send_item(FUNC_SEGMENT, 32'd5, 1'b0);
    send_item(FUNC_SEGMENT, 32'd5, 1'b1);
    send_item(FUNC_SEGMENT, 32'd5, 1'b0);
    send_item(FUNC_FLUSH, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_FLUSH, 32'h0, 1'b0);
    // short and long word boundaries
    send_item(FUNC_SEGMENT, 32'h7FFF, 1'b1);
    send_item(FUNC_SEGMENT, 32'h8000, 1'b0);
    send_item(FUNC_SEGMENT, 32'hFFFF, 1'b1);
    send_item(FUNC_SEGMENT, 32'h1_0000, 1'b0);
    send_item(FUNC_FLUSH, 32'h1234_5678, 1'b0);
    // segments above the limit and merges across it
    send_item(FUNC_SEGMENT, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_SEGMENT, 32'hFFFF_FFFF, 1'b0);
    send_item(FUNC_FLUSH, 32'h0, 1'b1);
    send_item(FUNC_SEGMENT, 32'h7FFF_FFFF, 1'b0);
    send_item(FUNC_SEGMENT, 32'd1, 1'b0);
    send_item(FUNC_SEGMENT, 32'h8000_0000, 1'b1);
    send_item(FUNC_SEGMENT, 32'h7FFF_FFFF, 1'b0);
    send_item(FUNC_FLUSH, 32'hFFFF_FFFF, 1'b0);

    while (items_sent < 175) random_block();
    settle();

    send_idle_pct = 88;
    recv_idle_pct = 36;
    while (items_sent < 330) random_block();
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    while (items_sent < 455) random_block();
    send_item(FUNC_FLUSH, 32'h0, 1'b0);
    settle();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
